// ===== rtl/bcpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bcpc_pkg
// Types, constants and syndrome functions for the BCH(31,21)+parity corrector.
// ----------------------------------------------------------------------------
`default_nettype none

package bcpc_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned CodeN     = 31;
  localparam int unsigned CodeK     = 21;
  localparam int unsigned RemW      = CodeN - CodeK;   // 10-bit remainder
  localparam int unsigned SynW      = RemW + 1;        // plus parity flag
  localparam int unsigned IdxW      = $clog2(WordW);
  localparam int unsigned FifoDepth = 4;

  localparam logic [RemW:0] Gen = 11'h769;

  typedef logic [WordW-1:0] word_t;
  typedef logic [SynW-1:0]  syn_t;
  typedef logic [IdxW-1:0]  idx_t;
  typedef logic [WordW-1:0][SynW-1:0] syn_tab_t;

  localparam idx_t IdxLast = idx_t'(WordW - 1);

  typedef enum logic [1:0] {
    ClsClean  = 2'd0,
    ClsSingle = 2'd1,
    ClsSearch = 2'd2,
    ClsFail   = 2'd3
  } cls_e;

  typedef enum logic [1:0] {
    StNone = 2'd0,
    StOne  = 2'd1,
    StTwo  = 2'd2,
    StFail = 2'd3
  } status_e;

  typedef enum logic {
    BkIdle = 1'b0,
    BkScan = 1'b1
  } bk_state_e;

  typedef struct packed {
    word_t word;
    syn_t  syn;
    cls_e  cls;
    idx_t  pos;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_st_t;

  typedef struct packed {
    logic hit;
    idx_t idx;
  } match_t;

  // Syndrome of a single set bit at each position. Bit 0 is the parity bit
  // alone; bit p>0 is x^(p-1) mod g, and every position flips the parity.
  function automatic syn_tab_t f_bit_syn_tab();
    syn_tab_t        tab;
    logic [CodeN-1:0] rem;
    tab    = '0;
    tab[0] = syn_t'(1) << RemW;
    for (int p = 1; p < WordW; p++) begin
      rem = CodeN'(1) << (p - 1);
      for (int k = CodeN - 1; k >= RemW; k--) begin
        if (rem[k]) begin
          rem = rem ^ (CodeN'(Gen) << (k - RemW));
        end
      end
      tab[p] = {1'b1, rem[RemW-1:0]};
    end
    return tab;
  endfunction

  localparam syn_tab_t BitSyn = f_bit_syn_tab();

  // Linear: XOR of the per-bit syndromes.
  function automatic syn_t f_syndrome(word_t w);
    syn_t s;
    s = '0;
    for (int i = 0; i < WordW; i++) begin
      if (w[i]) begin
        s = s ^ BitSyn[i];
      end
    end
    return s;
  endfunction

  // Compare against all single-bit syndromes; they are all distinct.
  function automatic match_t f_match(syn_t t);
    match_t m;
    m.hit = 1'b0;
    m.idx = '0;
    for (int i = WordW - 1; i >= 0; i--) begin
      if (t == BitSyn[i]) begin
        m.hit = 1'b1;
        m.idx = idx_t'(i);
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bcpc_in_if.sv =====
// ----------------------------------------------------------------------------
// bcpc_in_if
// Valid/ready channel carrying one received codeword item.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcpc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] codeword;

  modport source (output valid, output codeword, input ready);
  modport sink   (input valid, input codeword, output ready);
endinterface

`default_nettype wire

// ===== rtl/bcpc_out_if.sv =====
// ----------------------------------------------------------------------------
// bcpc_out_if
// Valid/ready channel carrying one corrected word and its status.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcpc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] corrected_word;
  logic [1:0]  status;

  modport source (output valid, output corrected_word, output status, input ready);
  modport sink   (input valid, input corrected_word, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/bcpc_front.sv =====
// ----------------------------------------------------------------------------
// bcpc_front
// Computes the syndrome and sorts each item: clean, single fix, pair search,
// or hopeless (odd parity with no single-bit match).
// ----------------------------------------------------------------------------
`default_nettype none

module bcpc_front (
  bcpc_in_if.sink              in_i,
  input  bcpc_pkg::fifo_st_t   q_st_i,
  output logic                 push_o,
  output bcpc_pkg::entry_t     entry_o
);
  import bcpc_pkg::*;

  syn_t   syn;
  match_t m;

  assign in_i.ready = !q_st_i.full;
  assign push_o     = in_i.valid && !q_st_i.full;

  always_comb begin
    syn           = f_syndrome(in_i.codeword);
    m             = f_match(syn);
    entry_o.word  = in_i.codeword;
    entry_o.syn   = syn;
    entry_o.pos   = m.idx;
    if (syn == '0) begin
      entry_o.cls = ClsClean;
    end else if (m.hit) begin
      entry_o.cls = ClsSingle;
    end else if (syn[SynW-1]) begin
      // odd weight but no single match: a pair cannot help either
      entry_o.cls = ClsFail;
    end else begin
      entry_o.cls = ClsSearch;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bcpc_fifo.sv =====
// ----------------------------------------------------------------------------
// bcpc_fifo
// Small register queue between the classifier and the correction engine.
// ----------------------------------------------------------------------------
`default_nettype none

module bcpc_fifo #(
  parameter int unsigned Depth = bcpc_pkg::FifoDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bcpc_pkg::entry_t   wdata_i,
  input  logic               pop_i,
  output bcpc_pkg::entry_t   rdata_o,
  output bcpc_pkg::fifo_st_t q_st_o
);
  import bcpc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign q_st_o.full  = (cnt_q == CntFull);
  assign q_st_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !q_st_o.full;
  assign do_pop       = pop_i && !q_st_o.empty;
  assign rdata_o      = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrLast) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrLast) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bcpc_back.sv =====
// ----------------------------------------------------------------------------
// bcpc_back
// Correction engine: applies single fixes at once, scans one first-bit
// position per cycle for pair errors, and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bcpc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bcpc_pkg::fifo_st_t q_st_i,
  input  bcpc_pkg::entry_t   entry_i,
  output logic               pop_o,
  bcpc_out_if.source         out_o
);
  import bcpc_pkg::*;

  bk_state_e state_q, state_d;
  logic      ov_q, ov_d;
  word_t     oword_q, oword_d;
  status_e   ostat_q, ostat_d;
  word_t     sword_q, sword_d;
  syn_t      ssyn_q, ssyn_d;
  idx_t      idx_q, idx_d;
  logic      out_free, emit;
  match_t    m;

  assign out_o.valid          = ov_q;
  assign out_o.corrected_word = oword_q;
  assign out_o.status         = ostat_q;
  assign out_free             = !ov_q || out_o.ready;

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    emit    = 1'b0;
    oword_d = oword_q;
    ostat_d = ostat_q;
    sword_d = sword_q;
    ssyn_d  = ssyn_q;
    idx_d   = idx_q;
    // residual after assuming the current position is one of the pair
    m       = f_match(ssyn_q ^ BitSyn[idx_q]);

    unique case (state_q)
      BkIdle: begin
        if (!q_st_i.empty) begin
          case (entry_i.cls) inside
            ClsSearch: begin
              pop_o   = 1'b1;
              sword_d = entry_i.word;
              ssyn_d  = entry_i.syn;
              idx_d   = '0;
              state_d = BkScan;
            end
            ClsClean, ClsSingle, ClsFail: begin
              if (out_free) begin
                pop_o = 1'b1;
                emit  = 1'b1;
                if (entry_i.cls == ClsSingle) begin
                  oword_d = entry_i.word ^ (word_t'(1) << entry_i.pos);
                  ostat_d = StOne;
                end else begin
                  oword_d = entry_i.word;
                  ostat_d = (entry_i.cls == ClsClean) ? StNone : StFail;
                end
              end
            end
            default: ;
          endcase
        end
      end
      BkScan: begin
        if (m.hit) begin
          if (out_free) begin
            emit    = 1'b1;
            oword_d = sword_q ^ (word_t'(1) << idx_q) ^ (word_t'(1) << m.idx);
            ostat_d = StTwo;
            state_d = BkIdle;
          end
        end else if (idx_q == IdxLast) begin
          if (out_free) begin
            emit    = 1'b1;
            oword_d = sword_q;
            ostat_d = StFail;
            state_d = BkIdle;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      default: state_d = BkIdle;
    endcase

    ov_d = out_free ? emit : ov_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oword_q <= oword_d;
    ostat_q <= ostat_d;
    sword_q <= sword_d;
    ssyn_q  <= ssyn_d;
    idx_q   <= idx_d;
  end

endmodule

`default_nettype wire

// ===== rtl/bch_31_21_parity_corrector_core.sv =====
// ----------------------------------------------------------------------------
// bch_31_21_parity_corrector_core
// Path: clean, single-error and odd-weight uncorrectable items go from the queue
//   straight to the output register; pair-search items first pass the scan.
// Throughput: one item per cycle while the output is taken, except pair search,
//   which holds the engine (a dispatch step, then one first-bit position per cycle).
// Reset: async active low; clears queue pointers, engine state, output valid.
// ----------------------------------------------------------------------------
`default_nettype none

// Structure
//   bcpc_front : syndrome (XOR of per-bit syndromes) plus 32 parallel compares
//                against the single-bit syndrome table; sorts the item.
//   bcpc_fifo  : short queue so input acceptance and correction stall apart.
//   bcpc_back  : applies the fix. For even-weight nonzero syndromes it walks
//                the first flip position i = 0..31, and checks S ^ s(i)
//                against the table; the code distance (6 with parity) makes
//                any match unique. No match after 32 steps -> uncorrectable.
//   Result sits in an output register; the engine can scan a pair-search item
//   while it waits to be taken, but other items wait until the output is free.

module bch_31_21_parity_corrector_core #(
  parameter int unsigned QDepth = bcpc_pkg::FifoDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bcpc_in_if.sink     in_i,
  bcpc_out_if.source  out_o
);
  import bcpc_pkg::*;

  fifo_st_t q_st;
  logic     push, pop;
  entry_t   wentry, rentry;

  bcpc_front u_front (
    .in_i    (in_i),
    .q_st_i  (q_st),
    .push_o  (push),
    .entry_o (wentry)
  );

  bcpc_fifo #(
    .Depth (QDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wentry),
    .pop_i   (pop),
    .rdata_o (rentry),
    .q_st_o  (q_st)
  );

  bcpc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .q_st_i  (q_st),
    .entry_i (rentry),
    .pop_o   (pop),
    .out_o   (out_o)
  );

  // Any word reported as clean or fixed must really be a codeword.
  a_fixed_is_codeword: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.status != StFail) |->
      f_syndrome(out_o.corrected_word) == '0)
    else $error("corrected word has nonzero syndrome");

  // An accepted item must be sitting in the queue on the next cycle.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !q_st.empty)
    else $error("accepted item did not reach the queue");

endmodule

`default_nettype wire
